[design/chained_hash_table_engine_unit_defines.svh]
// Assertion macros used by the hash table engine top level.
// Depends on nothing; included by files that carry assertions.
`ifndef CHAINED_HASH_TABLE_ENGINE_UNIT_DEFINES_SVH
`define CHAINED_HASH_TABLE_ENGINE_UNIT_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define CHTE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset.
`define CHTE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

[design/chte_pkg.sv]
// Package for the chained hash table engine: types, constants and the hash.
// Depends on nothing.
package chte_pkg;
   localparam int unsigned DefaultEntries = 1024;
   localparam logic [9:0] BucketReset = 10'd512;
   localparam logic [31:0] HashSeed = 32'd5381;

   typedef enum logic [1:0] {
      CMD_CLEAR = 2'd0,
      CMD_ADD   = 2'd1,
      CMD_FIND  = 2'd2,
      CMD_NEXT  = 2'd3
   } cmd_type;

   typedef struct packed {
      logic start;
      logic [31:0] dividend;
      logic [10:0] divisor;
   } mod_req_type;

   function automatic logic [31:0] hash_step(input logic [31:0] h, input logic [7:0] b);
      logic [31:0] sx;
      sx = {{24{b[7]}}, b};
      return ((h << 5) + h) ^ sx;
   endfunction
endpackage

[design/chte_ram.sv]
// Generic single-port RAM with registered read.
// Depends on nothing.
module chte_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

[design/chte_mod.sv]
// Restoring modulo unit, one quotient bit per cycle.
// Depends on chte_pkg.
module chte_mod (
   input  logic                 clock,
   input  logic                 reset,
   input  chte_pkg::mod_req_type req,
   output logic                 done,
   output logic [10:0]          remainder
);
   logic [31:0] dvd_ff, dvd_in;
   logic [11:0] rem_ff, rem_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [11:0] shifted;

   always_comb begin
      dvd_in = dvd_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      shifted = {rem_ff[10:0], dvd_ff[31]};
      if (req.start) begin
         dvd_in = req.dividend;
         rem_in = '0;
         cnt_in = 6'd32;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[30:0], 1'b0};
         rem_in = (shifted >= {1'b0, req.divisor}) ? shifted - {1'b0, req.divisor} : shifted;
         cnt_in = cnt_ff - 6'd1;
         busy_in = (cnt_ff != 6'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
   end

   assign done = busy_ff && (cnt_ff == 6'd1);
   assign remainder = rem_in[10:0];
endmodule

[design/chained_hash_table_engine_unit.sv]
// Top level of the chained hash table engine: sequencer and entry store.
// Depends on chte_pkg, chte_ram, chte_mod and the assertion macro header.
`include "chained_hash_table_engine_unit_defines.svh"
// A clear writes one store row per cycle (the same pass runs after reset and
// after a bucket count write); add and find hash the key and run the 32-step
// modulo; add, find and next visit chain entries through the single store
// port in states RADDR, RDATA and EVAL. Ready is low meanwhile.
module chained_hash_table_engine_unit #(
   parameter int unsigned ENTRIES = chte_pkg::DefaultEntries
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [31:0] req_key,
   input  logic [31:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_found,
   output logic [31:0] rsp_result_value,
   output logic        rsp_status,
   input  logic        csr_write,
   input  logic [9:0]  csr_wdata
);
   localparam int unsigned AW = $clog2(ENTRIES);
   localparam int unsigned RW = 1 + AW + 64;
   localparam logic [AW:0] EntCnt = (AW + 1)'(ENTRIES);

   typedef enum logic [9:0] {
      S_CLEAR = 10'b0000000001,
      S_IDLE  = 10'b0000000010,
      S_HASH  = 10'b0000000100,
      S_MOD   = 10'b0000001000,
      S_RADDR = 10'b0000010000,
      S_RDATA = 10'b0000100000,
      S_EVAL  = 10'b0001000000,
      S_LINK  = 10'b0010000000,
      S_WRITE = 10'b0100000000,
      S_RESP  = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   logic [9:0]  bcnt_ff, bcnt_in;
   logic [AW:0] nfree_ff, nfree_in;
   logic [AW-1:0] rlink_ff, rlink_in;
   logic [31:0] rkey_ff, rkey_in;
   logic [1:0]  cmd_ff, cmd_in;
   logic [31:0] key_ff, key_in, val_ff, val_in, hash_ff, hash_in;
   logic [1:0]  byte_ff, byte_in;
   logic [AW-1:0] cur_ff, cur_in, addr_ff, addr_in;
   logic [AW:0] steps_ff, steps_in;
   logic        found_ff, found_in, status_ff, status_in, rvld_ff, rvld_in;
   logic [31:0] rval_ff, rval_in;
   logic        we;
   logic [AW-1:0] ram_addr;
   logic [RW-1:0] wdata, rdata;
   logic [AW:0] effb, effb_raw;
   logic        r_used;
   logic [AW-1:0] r_next;
   logic [31:0] r_key, r_val;
   logic [10:0] rem;
   logic        mdone;
   chte_pkg::mod_req_type mreq;

   assign effb_raw = (bcnt_ff == '0) ? (AW + 1)'(1) : (AW + 1)'(bcnt_ff);
   assign effb = (32'(bcnt_ff) > ENTRIES) ? EntCnt : effb_raw;
   assign {r_used, r_next, r_key, r_val} = rdata;

   chte_ram #(.WIDTH(RW), .DEPTH(ENTRIES)) u_ram (
      .clock(clock), .wr_en(we), .addr(ram_addr), .wr_data(wdata), .rd_data(rdata)
   );

   chte_mod u_mod (.clock(clock), .reset(reset), .req(mreq), .done(mdone), .remainder(rem));

   assign req_ready = (state_ff == S_IDLE) && !rvld_ff;
   assign rsp_valid = rvld_ff;
   assign rsp_found = found_ff;
   assign rsp_result_value = rval_ff;
   assign rsp_status = status_ff;

   always_comb begin
      state_in = state_ff;
      bcnt_in = bcnt_ff;
      nfree_in = nfree_ff;
      rlink_in = rlink_ff;
      rkey_in = rkey_ff;
      cmd_in = cmd_ff;
      key_in = key_ff;
      val_in = val_ff;
      hash_in = hash_ff;
      byte_in = byte_ff;
      cur_in = cur_ff;
      addr_in = addr_ff;
      steps_in = steps_ff;
      found_in = found_ff;
      status_in = status_ff;
      rval_in = rval_ff;
      rvld_in = rvld_ff;
      we = 1'b0;
      ram_addr = addr_ff;
      wdata = '0;
      mreq.start = 1'b0;
      mreq.dividend = hash_ff;
      mreq.divisor = 11'(effb);
      if (rvld_ff && rsp_ready) begin
         rvld_in = 1'b0;
      end
      case (state_ff)
         S_CLEAR: begin
            we = 1'b1;
            ram_addr = cur_ff;
            cur_in = cur_ff + 1'b1;
            if (cur_ff == AW'(ENTRIES - 1)) begin
               if (cmd_ff == chte_pkg::CMD_CLEAR && steps_ff[0]) begin
                  state_in = S_RESP;
               end else begin
                  state_in = S_IDLE;
               end
               steps_in = '0;
            end
         end
         S_IDLE: begin
            if (req_valid && req_ready) begin
               cmd_in = req_command;
               key_in = req_key;
               val_in = req_value;
               hash_in = chte_pkg::HashSeed;
               byte_in = '0;
               found_in = 1'b0;
               status_in = 1'b0;
               rval_in = '0;
               steps_in = '0;
               case (chte_pkg::cmd_type'(req_command))
                  chte_pkg::CMD_CLEAR: begin
                     nfree_in = effb;
                     rlink_in = '0;
                     rkey_in = '0;
                     cur_in = '0;
                     steps_in = (AW + 1)'(1);
                     state_in = S_CLEAR;
                  end
                  chte_pkg::CMD_NEXT: begin
                     if (rlink_ff == '0) begin
                        state_in = S_RESP;
                     end else begin
                        key_in = rkey_ff;
                        cur_in = rlink_ff;
                        state_in = S_RADDR;
                     end
                  end
                  default: state_in = S_HASH;
               endcase
            end
         end
         S_HASH: begin
            hash_in = chte_pkg::hash_step(hash_ff, key_ff[8*byte_ff +: 8]);
            byte_in = byte_ff + 2'd1;
            if (byte_ff == 2'd3) begin
               state_in = S_MOD;
               mreq.start = 1'b1;
               mreq.dividend = hash_in;
            end
         end
         S_MOD: begin
            if (mdone) begin
               cur_in = AW'(rem);
               state_in = S_RADDR;
            end
         end
         S_RADDR: begin
            addr_in = cur_ff;
            state_in = S_RDATA;
         end
         S_RDATA: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            steps_in = steps_ff + 1'b1;
            if (cmd_ff == chte_pkg::CMD_ADD) begin
               if (steps_ff == '0 && !r_used) begin
                  state_in = S_WRITE;
               end else if (r_next != '0 && steps_ff < EntCnt - 1'b1) begin
                  cur_in = r_next;
                  state_in = S_RADDR;
               end else if (nfree_ff >= EntCnt) begin
                  status_in = 1'b1;
                  state_in = S_RESP;
               end else begin
                  state_in = S_LINK;
               end
            end else begin
               if (!r_used) begin
                  state_in = S_RESP;
               end else if (r_key == key_ff) begin
                  found_in = 1'b1;
                  rval_in = r_val;
                  rlink_in = r_next;
                  rkey_in = key_ff;
                  state_in = S_RESP;
               end else if (r_next == '0 || steps_ff >= EntCnt - 1'b1) begin
                  state_in = S_RESP;
               end else begin
                  cur_in = r_next;
                  state_in = S_RADDR;
               end
            end
         end
         S_LINK: begin
            we = 1'b1;
            wdata = {r_used, nfree_ff[AW-1:0], r_key, r_val};
            cur_in = nfree_ff[AW-1:0];
            addr_in = nfree_ff[AW-1:0];
            ram_addr = addr_ff;
            nfree_in = nfree_ff + 1'b1;
            state_in = S_WRITE;
         end
         S_WRITE: begin
            we = 1'b1;
            ram_addr = cur_ff;
            wdata = {1'b1, {AW{1'b0}}, key_ff, val_ff};
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rvld_ff) begin
               rvld_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (csr_write) begin
         bcnt_in = csr_wdata;
         nfree_in = ((csr_wdata == '0) ? (AW + 1)'(1)
                    : ((32'(csr_wdata) > ENTRIES) ? EntCnt : (AW + 1)'(csr_wdata)));
         rlink_in = '0;
         rkey_in = '0;
         cur_in = '0;
         cmd_in = chte_pkg::CMD_ADD;
         state_in = S_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         bcnt_ff <= chte_pkg::BucketReset;
         nfree_ff <= ((32'(chte_pkg::BucketReset) > ENTRIES) ? EntCnt
                     : (AW + 1)'(chte_pkg::BucketReset));
         rlink_ff <= '0;
         rkey_ff <= '0;
         cur_ff <= '0;
         cmd_ff <= chte_pkg::CMD_ADD;
         steps_ff <= '0;
         rvld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         bcnt_ff <= bcnt_in;
         nfree_ff <= nfree_in;
         rlink_ff <= rlink_in;
         rkey_ff <= rkey_in;
         cur_ff <= cur_in;
         cmd_ff <= cmd_in;
         steps_ff <= steps_in;
         rvld_ff <= rvld_in;
      end
      key_ff <= key_in;
      val_ff <= val_in;
      hash_ff <= hash_in;
      byte_ff <= byte_in;
      addr_ff <= addr_in;
      found_ff <= found_in;
      status_ff <= status_in;
      rval_ff <= rval_in;
   end

   `CHTE_ASSERT_IMP(a_ready_idle, clock, reset, req_ready, state_ff == S_IDLE, "ready outside idle")
   `CHTE_ASSERT_NEXT(a_accept_busy, clock, reset, req_valid && req_ready && !csr_write, !req_ready, "ready after accept")
   `CHTE_ASSERT_IMP(a_nfree_range, clock, reset, 1'b1, nfree_ff <= EntCnt, "free pointer out of range")
   `CHTE_ASSERT_IMP(a_full_add, clock, reset, rsp_valid && rsp_status, !rsp_found, "full and found together")
endmodule

[sim/tb_chained_hash_table_engine_unit.sv]
// Self-checking testbench for chained_hash_table_engine_unit: a stimulus table and
// random request phases under several bucket counts, checked against typed row results or a predictor.
// Depends on chte_pkg and the engine RTL only.
module tb_chained_hash_table_engine_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int Slots = 1024;
   localparam int CycleLimit = 5000000;
   localparam int PhaseItems = 92;

   typedef struct {
      logic        found;
      logic [31:0] value;
      logic        status;
   } lookup_result_type;

   typedef struct {
      chte_pkg::cmd_type cmd;
      logic [31:0] key;
      logic [31:0] value;
      bit          typed;
      logic        found;
      logic [31:0] result;
   } table_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_command = chte_pkg::CMD_CLEAR;
   logic [31:0] req_key = '0;
   logic [31:0] req_value = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_found;
   logic [31:0] rsp_result_value;
   logic        rsp_status;
   logic        csr_write = 1'b0;
   logic [9:0]  csr_wdata = '0;

   chained_hash_table_engine_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_command(req_command),
      .req_key(req_key), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_found(rsp_found),
      .rsp_result_value(rsp_result_value), .rsp_status(rsp_status),
      .csr_write(csr_write), .csr_wdata(csr_wdata)
   );

   // Shadow copy of the entry store.
   logic [9:0]  bucket_reg;
   logic [31:0] slot_key [Slots];
   logic [31:0] slot_value [Slots];
   bit          slot_used [Slots];
   int          slot_next [Slots];
   int          free_slot;
   int          resume_slot;
   logic [31:0] resume_match;

   lookup_result_type pending_results[$];
   int  failures = 0;
   int  cycles = 0;
   bit  quiet = 1'b0;

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CycleLimit) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic int active_buckets();
      int b;
      b = bucket_reg;
      if (b == 0) b = 1;
      if (b > Slots) b = Slots;
      return b;
   endfunction

   function automatic int bucket_of(logic [31:0] k);
      logic [31:0] h;
      logic [31:0] sx;
      h = 32'd5381;
      for (int i = 0; i < 4; i++) begin
         sx = {{24{k[8*i+7]}}, k[8*i +: 8]};
         h = (h * 32'd33) ^ sx;
      end
      return int'(h % active_buckets());
   endfunction

   function automatic void wipe_store();
      for (int i = 0; i < Slots; i++) begin
         slot_key[i] = '0;
         slot_value[i] = '0;
         slot_used[i] = 1'b0;
         slot_next[i] = 0;
      end
      free_slot = active_buckets();
      resume_slot = 0;
      resume_match = '0;
   endfunction

   function automatic int chain_search(int start, logic [31:0] k);
      int cur;
      cur = start;
      for (int s = 0; s < Slots; s++) begin
         if (cur >= Slots || !slot_used[cur]) return -1;
         if (slot_key[cur] == k) return cur;
         cur = slot_next[cur];
         if (cur == 0) return -1;
      end
      return -1;
   endfunction

   function automatic lookup_result_type apply_request(chte_pkg::cmd_type cmd, logic [31:0] k,
                                                       logic [31:0] v);
      lookup_result_type r;
      int head, tail, hit;
      r = '{1'b0, 32'd0, 1'b0};
      case (cmd)
         chte_pkg::CMD_CLEAR: begin
            wipe_store();
         end
         chte_pkg::CMD_ADD: begin
            head = bucket_of(k);
            if (!slot_used[head]) begin
               slot_key[head] = k;
               slot_value[head] = v;
               slot_used[head] = 1'b1;
               slot_next[head] = 0;
            end else begin
               tail = head;
               for (int s = 0; s < Slots; s++) begin
                  if (slot_next[tail] == 0 || slot_next[tail] >= Slots) break;
                  tail = slot_next[tail];
               end
               if (free_slot >= Slots) begin
                  r.status = 1'b1;
               end else begin
                  slot_key[free_slot] = k;
                  slot_value[free_slot] = v;
                  slot_used[free_slot] = 1'b1;
                  slot_next[free_slot] = 0;
                  slot_next[tail] = free_slot;
                  free_slot++;
               end
            end
         end
         chte_pkg::CMD_FIND: begin
            hit = chain_search(bucket_of(k), k);
            if (hit >= 0) begin
               r.found = 1'b1;
               r.value = slot_value[hit];
               resume_slot = slot_next[hit];
               resume_match = k;
            end
         end
         default: begin
            if (resume_slot != 0) begin
               hit = chain_search(resume_slot, resume_match);
               if (hit >= 0) begin
                  r.found = 1'b1;
                  r.value = slot_value[hit];
                  resume_slot = slot_next[hit];
               end
            end
         end
      endcase
      return r;
   endfunction

   function automatic bit take_gap();
      return !quiet && ($urandom_range(99) < 16);
   endfunction

   always @(posedge clock) begin
      lookup_result_type e;
      if (!reset) begin
         rsp_ready <= !take_gap();
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               $error("response with no request outstanding");
               failures++;
            end else begin
               e = pending_results.pop_front();
               if (rsp_found !== e.found) begin
                  $error("found: expected %0d, actual %0d", e.found, rsp_found);
                  failures++;
               end
               if (rsp_result_value !== e.value) begin
                  $error("result_value: expected %h, actual %h", e.value, rsp_result_value);
                  failures++;
               end
               if (rsp_status !== e.status) begin
                  $error("status: expected %0d, actual %0d", e.status, rsp_status);
                  failures++;
               end
            end
         end
      end
   end

   task automatic issue(chte_pkg::cmd_type cmd, logic [31:0] k, logic [31:0] v, bit typed,
                        lookup_result_type typed_result);
      lookup_result_type r;
      req_valid <= 1'b1;
      req_command <= cmd;
      req_key <= k;
      req_value <= v;
      do @(posedge clock); while (!req_ready);
      r = apply_request(cmd, k, v);
      pending_results.push_back(typed ? typed_result : r);
      if (take_gap()) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic drain();
      while (pending_results.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic set_buckets(logic [9:0] b);
      drain();
      csr_write <= 1'b1;
      csr_wdata <= b;
      @(posedge clock);
      csr_write <= 1'b0;
      bucket_reg = b;
      wipe_store();
   endtask

   task automatic random_phase(int count);
      logic [31:0] pool [8];
      logic [31:0] k;
      int pick;
      chte_pkg::cmd_type cmd;
      for (int i = 0; i < 8; i++) pool[i] = $urandom;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 3) cmd = chte_pkg::CMD_CLEAR;
         else if (pick < 45) cmd = chte_pkg::CMD_ADD;
         else if (pick < 72) cmd = chte_pkg::CMD_FIND;
         else cmd = chte_pkg::CMD_NEXT;
         k = ($urandom_range(9) < 2) ? $urandom : pool[$urandom_range(7)];
         issue(cmd, k, $urandom, 1'b0, '{1'b0, 32'd0, 1'b0});
      end
      req_valid <= 1'b0;
   endtask

   table_row_type directed_rows[] = '{
      '{chte_pkg::CMD_FIND,  32'h0000_0000, 32'h0,         1, 1'b0, 32'h0},
      '{chte_pkg::CMD_NEXT,  32'h0000_0000, 32'h0,         1, 1'b0, 32'h0},
      '{chte_pkg::CMD_ADD,   32'h0000_0000, 32'hFFFF_FFFF, 1, 1'b0, 32'h0},
      '{chte_pkg::CMD_FIND,  32'h0000_0000, 32'h0,         1, 1'b1, 32'hFFFF_FFFF},
      '{chte_pkg::CMD_ADD,   32'hFFFF_FFFF, 32'h0000_0000, 1, 1'b0, 32'h0},
      '{chte_pkg::CMD_ADD,   32'h0000_0000, 32'h0000_0001, 1, 1'b0, 32'h0},
      '{chte_pkg::CMD_ADD,   32'h0000_0000, 32'h8000_0000, 1, 1'b0, 32'h0},
      '{chte_pkg::CMD_FIND,  32'h0000_0000, 32'h0,         1, 1'b1, 32'hFFFF_FFFF},
      '{chte_pkg::CMD_NEXT,  32'h1234_5678, 32'h0,         1, 1'b1, 32'h0000_0001},
      '{chte_pkg::CMD_NEXT,  32'h0000_0000, 32'h0,         1, 1'b1, 32'h8000_0000},
      '{chte_pkg::CMD_NEXT,  32'h0000_0000, 32'h0,         1, 1'b0, 32'h0},
      '{chte_pkg::CMD_FIND,  32'hFFFF_FFFF, 32'h0,         1, 1'b1, 32'h0000_0000},
      '{chte_pkg::CMD_ADD,   32'h8080_8080, 32'hA5A5_5A5A, 0, 1'b0, 32'h0},
      '{chte_pkg::CMD_ADD,   32'h7F7F_7F7F, 32'h5A5A_A5A5, 0, 1'b0, 32'h0},
      '{chte_pkg::CMD_FIND,  32'h8080_8080, 32'h0,         0, 1'b0, 32'h0},
      '{chte_pkg::CMD_FIND,  32'h7F7F_7F7F, 32'h0,         0, 1'b0, 32'h0},
      '{chte_pkg::CMD_FIND,  32'hDEAD_BEEF, 32'h0,         1, 1'b0, 32'h0},
      '{chte_pkg::CMD_NEXT,  32'h0000_0000, 32'h0,         0, 1'b0, 32'h0},
      '{chte_pkg::CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1'b0, 32'h0},
      '{chte_pkg::CMD_FIND,  32'h0000_0000, 32'h0,         1, 1'b0, 32'h0},
      '{chte_pkg::CMD_NEXT,  32'h0000_0000, 32'h0,         1, 1'b0, 32'h0}
   };

   logic [9:0] bucket_plan[] = '{10'd1023, 10'd0, 10'd7, 10'd1, 10'd64, 10'd3, 10'd512,
                                 10'd1023};

   initial begin
      bucket_reg = chte_pkg::BucketReset;
      wipe_store();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed_rows[i]) begin
         issue(directed_rows[i].cmd, directed_rows[i].key, directed_rows[i].value,
               directed_rows[i].typed,
               '{directed_rows[i].found, directed_rows[i].result, 1'b0});
      end
      req_valid <= 1'b0;
      foreach (bucket_plan[p]) begin
         set_buckets(bucket_plan[p]);
         quiet = (p == 2);
         random_phase(PhaseItems);
      end
      quiet = 1'b0;
      drain();
      if (failures == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
